/* rtl/cfba_pkg.sv */
// ----------------------------------------------------------------------------
// Chained free-block allocator package
// Shared constants, operation and result codes, and the controller state type.
// ----------------------------------------------------------------------------
package cfba_pkg;

  localparam int unsigned StackEntriesDef = 50;
  localparam int unsigned BlockBitsDef    = 16;

  localparam int unsigned ValueW = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned IndexW = 6;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_LOAD_COUNT = 2'd2,
    OP_LOAD_ENTRY = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOCATED = 3'd0,
    KIND_NO_SPACE  = 3'd1,
    KIND_SPILL     = 3'd2,
    KIND_ACCEPTED  = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

/* rtl/cfba_ram.sv */
// ----------------------------------------------------------------------------
// Free stack memory
// Single write port and single registered read port.
// ----------------------------------------------------------------------------
module cfba_ram #(
  parameter int unsigned Depth = cfba_pkg::StackEntriesDef,
  parameter int unsigned Width = cfba_pkg::BlockBitsDef
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/chained_free_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Chained free-block allocator
// Cached stack of free block numbers with chain loading and full-stack spill.
// ----------------------------------------------------------------------------
//  Channel | Valid / ready            | Payload
//  input   | in_valid_i / in_ready_o  | op_i, block_value_i
//  output  | out_valid_o / out_ready_i| kind_o, block_number_o, spill_target_o,
//          |                          | entry_index_o, spill_total_o,
//          |                          | fetch_chain_o, last_o
//
// Each transaction is accepted in the idle state, where the stack memory
// read starts, and is then executed in the execute state. A free onto a full
// stack stays in the execute state while the single read port walks every entry.
// The stack memory is not cleared at reset; only counters and flags are.
// A stalled output holds the result and the controller waits in its execute
// state, while a new transaction may be accepted as soon as it is idle.
// ----------------------------------------------------------------------------
module chained_free_block_allocator_unit #(
  parameter int unsigned STACK_ENTRIES = cfba_pkg::StackEntriesDef,
  parameter int unsigned BLOCK_BITS    = cfba_pkg::BlockBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [cfba_pkg::ValueW-1:0] block_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cfba_pkg::KindW-1:0]  kind_o,
  output logic [cfba_pkg::ValueW-1:0] block_number_o,
  output logic [cfba_pkg::ValueW-1:0] spill_target_o,
  output logic [cfba_pkg::IndexW-1:0] entry_index_o,
  output logic [cfba_pkg::IndexW-1:0] spill_total_o,
  output logic                        fetch_chain_o,
  output logic                        last_o
);

  localparam int unsigned StoreW = (BLOCK_BITS < cfba_pkg::ValueW) ? BLOCK_BITS
                                                                    : cfba_pkg::ValueW;
  localparam int unsigned IdxW   = $clog2(STACK_ENTRIES);
  localparam int unsigned CntW   = $clog2(STACK_ENTRIES + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_ENTRIES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(STACK_ENTRIES - 1);

  cfba_pkg::state_e state_q, state_d;
  cfba_pkg::op_e    op_q;
  logic [StoreW-1:0] val_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              loading_q, loading_d;
  logic [CntW-1:0]   exp_q, exp_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   spill_idx_q, spill_idx_d;

  logic                        out_valid_q, out_valid_d;
  cfba_pkg::kind_e             out_kind_q;
  logic [cfba_pkg::ValueW-1:0] out_block_q, out_target_q;
  logic [cfba_pkg::IndexW-1:0] out_index_q, out_total_q;
  logic                        out_fetch_q, out_last_q;

  logic                        accept_in, slot_free, spilling, exec_done;
  logic                        res_valid, res_fetch, res_last;
  cfba_pkg::kind_e             res_kind;
  logic [cfba_pkg::ValueW-1:0] res_block, res_target;
  logic [cfba_pkg::IndexW-1:0] res_index, res_total;
  logic [CntW-1:0]             clamp_count, pos_next;

  logic              wr_en, rd_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic [StoreW-1:0] rd_data;

  cfba_ram #(
    .Depth(STACK_ENTRIES),
    .Width(StoreW)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (val_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign accept_in = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign spilling  = (op_q == cfba_pkg::OP_FREE) && !loading_q && (count_q >= CntFull);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfba_pkg::ST_IDLE: begin
        if (accept_in) begin
          state_d = cfba_pkg::ST_EXEC;
        end
      end
      cfba_pkg::ST_EXEC: begin
        if (exec_done) begin
          state_d = cfba_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == cfba_pkg::ST_IDLE);
    rd_en      = 1'b0;
    rd_addr    = '0;
    if (accept_in) begin
      rd_en = 1'b1;
      if ((op_i == cfba_pkg::OP_ALLOC) && (count_q != '0)) begin
        rd_addr = IdxW'(count_q - 1'b1);
      end
    end else if ((state_q == cfba_pkg::ST_EXEC) && spilling && slot_free &&
                 (spill_idx_q != IdxLast)) begin
      rd_en   = 1'b1;
      rd_addr = spill_idx_q + 1'b1;
    end
  end

  assign clamp_count = (cfba_pkg::ValueW'(val_q) > cfba_pkg::ValueW'(STACK_ENTRIES))
                       ? CntFull : CntW'(val_q);
  assign pos_next    = pos_q + 1'b1;

  always_comb begin
    count_d     = count_q;
    loading_d   = loading_q;
    exp_d       = exp_q;
    pos_d       = pos_q;
    spill_idx_d = spill_idx_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    exec_done   = 1'b0;
    res_valid   = 1'b0;
    res_kind    = cfba_pkg::KIND_REJECTED;
    res_block   = '0;
    res_target  = '0;
    res_index   = '0;
    res_total   = '0;
    res_fetch   = 1'b0;
    res_last    = 1'b1;
    if ((state_q == cfba_pkg::ST_EXEC) && slot_free) begin
      res_valid = 1'b1;
      unique case (op_q)
        cfba_pkg::OP_ALLOC: begin
          exec_done = 1'b1;
          if (loading_q) begin
            res_kind = cfba_pkg::KIND_REJECTED;
          end else if (count_q == '0) begin
            res_kind = cfba_pkg::KIND_NO_SPACE;
          end else begin
            count_d = count_q - 1'b1;
            if (rd_data == '0) begin
              res_kind = cfba_pkg::KIND_NO_SPACE;
            end else begin
              res_kind  = cfba_pkg::KIND_ALLOCATED;
              res_block = cfba_pkg::ValueW'(rd_data);
              if (count_q == CntW'(1)) begin
                res_fetch = 1'b1;
                loading_d = 1'b1;
                exp_d     = '0;
                pos_d     = '0;
              end
            end
          end
        end
        cfba_pkg::OP_FREE: begin
          if (loading_q) begin
            exec_done = 1'b1;
            res_kind  = cfba_pkg::KIND_REJECTED;
          end else if (spilling) begin
            res_kind   = cfba_pkg::KIND_SPILL;
            res_block  = cfba_pkg::ValueW'(rd_data);
            res_target = cfba_pkg::ValueW'(val_q);
            res_index  = cfba_pkg::IndexW'(spill_idx_q);
            res_total  = cfba_pkg::IndexW'(STACK_ENTRIES);
            res_last   = 1'b0;
            if (spill_idx_q == IdxLast) begin
              count_d     = '0;
              spill_idx_d = '0;
            end else begin
              spill_idx_d = spill_idx_q + 1'b1;
            end
          end else begin
            exec_done = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = count_q[IdxW-1:0];
            count_d   = count_q + 1'b1;
            res_kind  = cfba_pkg::KIND_ACCEPTED;
          end
        end
        cfba_pkg::OP_LOAD_COUNT: begin
          exec_done = 1'b1;
          if (!loading_q || (exp_q != '0)) begin
            res_kind = cfba_pkg::KIND_REJECTED;
          end else begin
            exp_d    = clamp_count;
            pos_d    = '0;
            count_d  = '0;
            res_kind = cfba_pkg::KIND_ACCEPTED;
            if (clamp_count == '0) begin
              loading_d = 1'b0;
            end
          end
        end
        cfba_pkg::OP_LOAD_ENTRY: begin
          exec_done = 1'b1;
          if (!loading_q || (pos_q >= exp_q)) begin
            res_kind = cfba_pkg::KIND_REJECTED;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = pos_q[IdxW-1:0];
            count_d  = pos_next;
            res_kind = cfba_pkg::KIND_ACCEPTED;
            if (pos_next == exp_q) begin
              loading_d = 1'b0;
              exp_d     = '0;
              pos_d     = '0;
            end else begin
              pos_d = pos_next;
            end
          end
        end
      endcase
    end
  end

  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfba_pkg::ST_IDLE;
      count_q     <= '0;
      loading_q   <= 1'b0;
      exp_q       <= '0;
      pos_q       <= '0;
      spill_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      loading_q   <= loading_d;
      exp_q       <= exp_d;
      pos_q       <= pos_d;
      spill_idx_q <= spill_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q  <= cfba_pkg::op_e'(op_i);
      val_q <= block_value_i[StoreW-1:0];
    end
    if (res_valid) begin
      out_kind_q   <= res_kind;
      out_block_q  <= res_block;
      out_target_q <= res_target;
      out_index_q  <= res_index;
      out_total_q  <= res_total;
      out_fetch_q  <= res_fetch;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign block_number_o = out_block_q;
  assign spill_target_o = out_target_q;
  assign entry_index_o  = out_index_q;
  assign spill_total_o  = out_total_q;
  assign fetch_chain_o  = out_fetch_q;
  assign last_o         = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("The stack count exceeds the stack size.");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !loading_q |-> ((exp_q == '0) && (pos_q == '0)))
    else $error("Load progress is held while no chain load is pending.");

  a_load_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loading_q |-> ((pos_q < exp_q) || (pos_q == '0)))
    else $error("The load position has passed the expected chain count.");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == cfba_pkg::ST_EXEC))
    else $error("An accepted transaction did not enter execution.");

  a_not_last_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (out_kind_q == cfba_pkg::KIND_SPILL))
    else $error("Only spill results may precede the final result.");

  a_fetch_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fetch_chain_o) |-> (out_kind_q == cfba_pkg::KIND_ALLOCATED))
    else $error("A chain fetch was flagged on a result that is not an allocation.");
`endif

endmodule
